// ===== sv/ckcs_pkg.sv =====
// Shared constants, types and helpers for the color keyframe curve sampler.
package ckcs_pkg;

	localparam int POS_W     = 17;
	localparam int SPOS_W    = 18;
	localparam int CHAN_W    = 16;
	localparam int NCHAN     = 3;
	localparam int COLOR_W   = NCHAN * CHAN_W;
	localparam int KIDX_W    = 3;
	localparam int CNT_W     = 4;
	localparam int QUO_W     = 17;
	localparam int MAX_KEYS_DEF = 8;

	localparam int IN_BITS   = KIDX_W + POS_W + NCHAN * CHAN_W + SPOS_W;
	localparam int IN_DATA_W = ((IN_BITS + 7) / 8) * 8;
	localparam int OUT_DATA_W = ((COLOR_W + 7) / 8) * 8;

	localparam logic [POS_W-1:0]  ONE_POS = 17'h10000;
	localparam logic [CHAN_W-1:0] WHITE_Q412 = 16'h1000;

	localparam logic KIND_WRITE  = 1'b0;
	localparam logic KIND_SAMPLE = 1'b1;

	typedef logic [POS_W-1:0]   pos_t;
	typedef logic [CHAN_W-1:0]  chan_t;
	typedef logic [COLOR_W-1:0] color_t;
	typedef logic [QUO_W-1:0]   quo_t;

	// Table layout: red in the top channel, blue in the bottom one.
	function automatic chan_t chan_of(input color_t c, input int ch);
		chan_t r;
		r = c[COLOR_W - 1 - ch * CHAN_W -: CHAN_W];
		return r;
	endfunction

endpackage

// ===== sv/color_keyframe_curve_sampler.sv =====
// Flow: a keypoint write goes into both tables at its beat; a sample runs the segment search,
// which passes over 0 .. key_count-2 table slots, then the divide and the lerp, and raises tvalid.
// The search reads one keypoint per cycle; the quotient and the lerp each run 17 bit steps.
// An empty curve goes straight to S_OUT; an end hit goes to S_OUT from S_RD0 or S_RDL.
// Throughput: one item in work at a time; s_axis_tready rises again together with tvalid.
// Reset (arst_n low, asynchronous) clears key_count and all control state; tables are not cleared.
module color_keyframe_curve_sampler
	import ckcs_pkg::*;
#(
	parameter int MAX_KEYS = MAX_KEYS_DEF
) (
	input  logic                  clk,
	input  logic                  arst_n,
	// Input stream, one beat is one item.
	input  logic                  s_axis_tvalid,
	output logic                  s_axis_tready,
	// From bit 0: key_index[3], key_pos[17], key_red[16], key_green[16],
	// key_blue[16], sample_pos[18], two zero bits.
	input  logic [IN_DATA_W-1:0]  s_axis_tdata,
	// Bit 0: kind (0 writes a keypoint, 1 samples the curve).
	input  logic [0:0]            s_axis_tuser,
	// Result stream, one beat per sample.
	output logic                  m_axis_tvalid,
	input  logic                  m_axis_tready,
	// From bit 0: red_out[16], green_out[16], blue_out[16].
	output logic [OUT_DATA_W-1:0] m_axis_tdata,
	// key_count register write channel.
	input  logic                  cfg_valid,
	output logic                  cfg_ready,
	input  logic [CNT_W-1:0]      cfg_data
);

	localparam int IW = $clog2(MAX_KEYS);
	localparam int CW = (IW + 1 > CNT_W) ? IW + 1 : CNT_W;
	// One bit above both the slot field and the table index, so that the table
	// size itself fits for the range check.
	localparam int SW = ((IW > KIDX_W) ? IW : KIDX_W) + 1;

	localparam logic [2:0] S_IDLE = 3'd0;
	localparam logic [2:0] S_RD0  = 3'd1;
	localparam logic [2:0] S_RDL  = 3'd2;
	localparam logic [2:0] S_SCAN = 3'd3;
	localparam logic [2:0] S_DIV  = 3'd4;
	localparam logic [2:0] S_LERP = 3'd5;
	localparam logic [2:0] S_OUT  = 3'd6;

	// Unpacked input fields.
	logic [KIDX_W-1:0]        key_index;
	pos_t                     key_pos;
	chan_t                    key_red, key_green, key_blue;
	logic signed [SPOS_W-1:0] sample_pos;
	logic                     kind;

	assign key_index  = s_axis_tdata[KIDX_W-1:0];
	assign key_pos    = s_axis_tdata[KIDX_W +: POS_W];
	assign key_red    = s_axis_tdata[KIDX_W + POS_W +: CHAN_W];
	assign key_green  = s_axis_tdata[KIDX_W + POS_W + CHAN_W +: CHAN_W];
	assign key_blue   = s_axis_tdata[KIDX_W + POS_W + 2 * CHAN_W +: CHAN_W];
	assign sample_pos = s_axis_tdata[KIDX_W + POS_W + 3 * CHAN_W +: SPOS_W];
	assign kind       = s_axis_tuser[0];

	logic [2:0]       state_q;
	logic [CNT_W-1:0] key_count_q;
	pos_t             t_q, pa_q;
	color_t           ca_q, cb_q, res_q;
	logic [IW-1:0]    idx_q;
	logic             m_valid_q;
	logic [OUT_DATA_W-1:0] m_data_q;

	logic             in_beat;
	logic [IW-1:0]    last_idx;
	logic [CW-1:0]    count_ext;
	logic [SW-1:0]    slot_ext;
	logic             wr_en;
	pos_t             wr_pos;
	logic [IW-1:0]    rd_addr;
	pos_t             pos_rdata;
	color_t           color_rdata;
	pos_t             t_clamp;
	logic             scan_hit;
	logic [POS_W:0]   span_full;
	pos_t             span;
	pos_t             diff;
	logic             div_done;
	quo_t             quo;
	logic             lerp_done;
	color_t           lerp_color;
	logic             out_free;

	assign s_axis_tready = (state_q == S_IDLE);
	assign in_beat       = s_axis_tvalid && s_axis_tready;
	assign cfg_ready     = 1'b1;
	assign m_axis_tvalid = m_valid_q;
	assign m_axis_tdata  = m_data_q;
	assign out_free      = !m_valid_q || m_axis_tready;

	// A count beyond the table size acts as the table size.
	assign count_ext = CW'(key_count_q);
	assign last_idx  = (count_ext > CW'(MAX_KEYS)) ? IW'(MAX_KEYS - 1) :
	                   IW'(count_ext - CW'(1));

	// Keypoint writes go straight into both tables; slots past the table are dropped.
	assign slot_ext = SW'(key_index);
	assign wr_en    = in_beat && (kind == KIND_WRITE) && (slot_ext < SW'(MAX_KEYS));
	assign wr_pos   = (key_pos > ONE_POS) ? ONE_POS : key_pos;

	// The sample position is clamped to the range zero to one.
	always_comb begin
		if (sample_pos < 0) begin
			t_clamp = '0;
		end else if (sample_pos > $signed({1'b0, ONE_POS})) begin
			t_clamp = ONE_POS;
		end else begin
			t_clamp = sample_pos[POS_W-1:0];
		end
	end

	// Read address for the data that arrives in the next state.
	always_comb begin
		case (state_q)
			S_IDLE:  rd_addr = '0;
			S_RD0:   rd_addr = last_idx;
			S_RDL:   rd_addr = IW'(1);
			S_SCAN:  rd_addr = idx_q + IW'(1);
			default: rd_addr = '0;
		endcase
	end

	ckcs_ram #(.WIDTH(POS_W), .DEPTH(MAX_KEYS)) u_pos_ram (
		.clk   (clk),
		.we    (wr_en),
		.waddr (slot_ext[IW-1:0]),
		.wdata (wr_pos),
		.raddr (rd_addr),
		.rdata (pos_rdata)
	);

	ckcs_ram #(.WIDTH(COLOR_W), .DEPTH(MAX_KEYS)) u_color_ram (
		.clk   (clk),
		.we    (wr_en),
		.waddr (slot_ext[IW-1:0]),
		.wdata ({key_red, key_green, key_blue}),
		.raddr (rd_addr),
		.rdata (color_rdata)
	);

	// The segment ends at the first keypoint at or after the position. The
	// span is clamped to one so that an unsorted table still divides.
	assign scan_hit  = (state_q == S_SCAN) && (t_q <= pos_rdata);
	assign span_full = {1'b0, pos_rdata} - {1'b0, pa_q};
	assign span      = (span_full[POS_W] || (span_full == '0)) ? POS_W'(1) : span_full[POS_W-1:0];
	assign diff      = t_q - pa_q;

	ckcs_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (scan_hit),
		.diff   (diff),
		.span   (span),
		.done   (div_done),
		.quo    (quo)
	);

	ckcs_lerp u_lerp (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (div_done),
		.ca     (ca_q),
		.cb     (cb_q),
		.u      (quo),
		.done   (lerp_done),
		.color  (lerp_color)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			key_count_q <= '0;
			m_valid_q   <= 1'b0;
		end else begin
			if (cfg_valid && cfg_ready) begin
				key_count_q <= cfg_data;
			end
			if (state_q == S_OUT && out_free) begin
				m_valid_q <= 1'b1;
			end else if (m_axis_tready) begin
				m_valid_q <= 1'b0;
			end
			case (state_q)
				S_IDLE: begin
					if (in_beat && kind == KIND_SAMPLE) begin
						state_q <= (key_count_q == '0) ? S_OUT : S_RD0;
					end
				end
				S_RD0: begin
					state_q <= (t_q <= pos_rdata) ? S_OUT : S_RDL;
				end
				S_RDL: begin
					state_q <= (t_q >= pos_rdata) ? S_OUT : S_SCAN;
				end
				S_SCAN: begin
					if (scan_hit) begin
						state_q <= S_DIV;
					end
				end
				S_DIV: begin
					if (div_done) begin
						state_q <= S_LERP;
					end
				end
				S_LERP: begin
					if (lerp_done) begin
						state_q <= S_OUT;
					end
				end
				S_OUT: begin
					if (out_free) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	// Datapath registers.
	always_ff @(posedge clk) begin
		case (state_q)
			S_IDLE: begin
				t_q   <= t_clamp;
				res_q <= {WHITE_Q412, WHITE_Q412, WHITE_Q412};
			end
			S_RD0: begin
				pa_q  <= pos_rdata;
				ca_q  <= color_rdata;
				res_q <= color_rdata;
			end
			S_RDL: begin
				res_q <= color_rdata;
				idx_q <= IW'(1);
			end
			S_SCAN: begin
				if (scan_hit) begin
					cb_q <= color_rdata;
				end else begin
					pa_q  <= pos_rdata;
					ca_q  <= color_rdata;
					idx_q <= idx_q + IW'(1);
				end
			end
			S_LERP: begin
				if (lerp_done) begin
					res_q <= lerp_color;
				end
			end
			S_OUT: begin
				if (out_free) begin
					m_data_q <= OUT_DATA_W'({chan_of(res_q, 2), chan_of(res_q, 1),
					                         chan_of(res_q, 0)});
				end
			end
			default: begin
			end
		endcase
	end

endmodule

// ===== sv/ckcs_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
module ckcs_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 8
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata_q <= mem_q[raddr];
	end

	assign rdata = rdata_q;

endmodule

// ===== sv/ckcs_div.sv =====
// Restoring divider, one quotient bit per cycle: quo = floor(diff * 2^16 / span).
module ckcs_div
	import ckcs_pkg::*;
(
	input  logic clk,
	input  logic arst_n,
	input  logic start,
	input  pos_t diff,
	input  pos_t span,
	output logic done,
	output quo_t quo
);

	logic [POS_W:0]   rem_q;
	pos_t             den_q;
	quo_t             quo_q;
	logic [4:0]       cnt_q;
	logic             busy_q;
	logic             done_q;
	logic [POS_W:0]   trial;
	logic             ge;

	// The first step compares the plain dividend; the integer bit is set only
	// when diff is at least span. Each later step shifts in one zero bit.
	always_comb begin
		trial = (cnt_q == 5'd0) ? rem_q : {rem_q[POS_W-1:0], 1'b0};
		ge    = trial >= {1'b0, den_q};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 5'd1;
				if (cnt_q == 5'(QUO_W - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= {1'b0, diff};
			den_q <= span;
			quo_q <= '0;
		end else if (busy_q) begin
			rem_q <= ge ? (trial - {1'b0, den_q}) : trial;
			quo_q <= {quo_q[QUO_W-2:0], ge};
		end
	end

	assign done = done_q;
	assign quo  = quo_q;

endmodule

// ===== sv/ckcs_lerp.sv =====
// Bit-serial lerp of three channels: ca + floor((cb - ca) * u / 2^16), LSB of u first.
module ckcs_lerp
	import ckcs_pkg::*;
(
	input  logic   clk,
	input  logic   arst_n,
	input  logic   start,
	input  color_t ca,
	input  color_t cb,
	input  quo_t   u,
	output logic   done,
	output color_t color
);

	logic signed [CHAN_W:0]   d_q   [NCHAN];
	logic signed [CHAN_W+1:0] acc_q [NCHAN];
	chan_t                    ca_q  [NCHAN];
	quo_t                     u_q;
	logic [4:0]               cnt_q;
	logic                     busy_q;
	logic                     done_q;
	logic signed [CHAN_W+1:0] sum   [NCHAN];

	always_comb begin
		for (int c = 0; c < NCHAN; c++) begin
			sum[c] = acc_q[c] + (u_q[0] ? {d_q[c][CHAN_W], d_q[c]} : '0);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 5'd1;
				if (cnt_q == 5'(QUO_W - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// The fraction bits are shifted out with a floor at each step, which
	// composes to one floor of the whole product. The integer bit of u adds
	// the full delta without a shift.
	always_ff @(posedge clk) begin
		if (start) begin
			u_q <= u;
			for (int c = 0; c < NCHAN; c++) begin
				ca_q[c]  <= chan_of(ca, c);
				d_q[c]   <= $signed({1'b0, chan_of(cb, c)}) - $signed({1'b0, chan_of(ca, c)});
				acc_q[c] <= '0;
			end
		end else if (busy_q) begin
			u_q <= {1'b0, u_q[QUO_W-1:1]};
			for (int c = 0; c < NCHAN; c++) begin
				acc_q[c] <= (cnt_q == 5'(QUO_W - 1)) ? sum[c] : (sum[c] >>> 1);
			end
		end
	end

	always_comb begin
		logic [CHAN_W+1:0] r;
		color = '0;
		for (int c = 0; c < NCHAN; c++) begin
			r = {2'b00, ca_q[c]} + acc_q[c];
			color[COLOR_W - 1 - c * CHAN_W -: CHAN_W] = r[CHAN_W-1:0];
		end
	end

	assign done = done_q;

endmodule

// ===== tb/color_keyframe_curve_sampler_tb.sv =====
// Self-checking testbench for the color keyframe curve sampler.
module color_keyframe_curve_sampler_tb;
	import ckcs_pkg::*;

	localparam int CYCLE_LIMIT = 1000000;
	// Covers the longest sample (full segment scan, divide and lerp) with margin.
	localparam int SETTLE_CYCLES = 64;
	localparam int RANDOM_PER_PHASE = 100;
	localparam int NPHASES = 12;

	// One input beat before packing.
	typedef struct {
		logic                     kind;
		logic [KIDX_W-1:0]        key_index;
		logic [POS_W-1:0]         key_pos;
		chan_t                    red;
		chan_t                    green;
		chan_t                    blue;
		logic signed [SPOS_W-1:0] sample_pos;
	} curve_item_t;

	// Tracks the keypoint table and key_count, predicts the color of each
	// sample and checks result beats in order.
	class curve_scoreboard;
		pos_t                  key_pos [MAX_KEYS_DEF];
		chan_t                 key_chan [MAX_KEYS_DEF][NCHAN];
		logic [CNT_W-1:0]      key_count;
		logic [OUT_DATA_W-1:0] expected_colors [$];
		string                 chan_names [NCHAN] = '{"red", "green", "blue"};
		int                    errors;

		function new();
			key_count = '0;
			errors = 0;
		endfunction

		function int pending();
			return expected_colors.size();
		endfunction

		// Result packing: red in the low channel, blue in the high one.
		function logic [OUT_DATA_W-1:0] slot_color(int unsigned k);
			return {key_chan[k][2], key_chan[k][1], key_chan[k][0]};
		endfunction

		function logic [OUT_DATA_W-1:0] color_at(logic signed [SPOS_W-1:0] spos);
			int unsigned           n, t, seg, pa;
			longint                sp;
			longint unsigned       diff, span_u, u, ca, cb, mix;
			logic [OUT_DATA_W-1:0] c;
			n = (key_count > MAX_KEYS_DEF) ? MAX_KEYS_DEF : 32'(key_count);
			if (n == 0)
				return {WHITE_Q412, WHITE_Q412, WHITE_Q412};
			if (spos < 0)
				t = 0;
			else if (spos > 65536)
				t = 65536;
			else
				t = int'(spos);
			if (t <= key_pos[0])
				return slot_color(0);
			if (t >= key_pos[n-1])
				return slot_color(n-1);
			// t lies below the last position, so the search stops by slot n-1.
			seg = 1;
			while (t > key_pos[seg])
				seg++;
			pa = key_pos[seg-1];
			sp = longint'(key_pos[seg]) - longint'(pa);
			if (sp < 1)
				sp = 1;
			span_u = sp;
			diff = 64'(t - pa);
			u = (diff << 16) / span_u;
			if (u > 65536)
				u = 65536;
			for (int ch = 0; ch < NCHAN; ch++) begin
				ca = 64'(key_chan[seg-1][ch]);
				cb = 64'(key_chan[seg][ch]);
				mix = (ca * (64'd65536 - u) + cb * u) >> 16;
				c[ch*CHAN_W +: CHAN_W] = mix[CHAN_W-1:0];
			end
			return c;
		endfunction

		function void note_item(curve_item_t it);
			if (it.kind == KIND_WRITE) begin
				key_pos[it.key_index] = (it.key_pos > ONE_POS) ? ONE_POS : it.key_pos;
				key_chan[it.key_index][0] = it.red;
				key_chan[it.key_index][1] = it.green;
				key_chan[it.key_index][2] = it.blue;
			end else begin
				expected_colors = {expected_colors, color_at(it.sample_pos)};
			end
		endfunction

		function void check_color(logic [OUT_DATA_W-1:0] got);
			logic [OUT_DATA_W-1:0] want;
			if (expected_colors.size() == 0) begin
				errors++;
				$display("%0t: ERROR color beat with none expected: expected nothing, actual %h",
					$time, got);
				return;
			end
			want = expected_colors.pop_front();
			for (int ch = 0; ch < NCHAN; ch++) begin
				if (got[ch*CHAN_W +: CHAN_W] !== want[ch*CHAN_W +: CHAN_W]) begin
					errors++;
					$display("%0t: ERROR %s channel: expected %h, actual %h", $time,
						chan_names[ch], want[ch*CHAN_W +: CHAN_W], got[ch*CHAN_W +: CHAN_W]);
				end
			end
		endfunction
	endclass

	logic                  clk = 1'b0;
	logic                  arst_n = 1'b0;
	logic                  s_axis_tvalid = 1'b0;
	logic                  s_axis_tready;
	logic [IN_DATA_W-1:0]  s_axis_tdata = '0;
	logic [0:0]            s_axis_tuser = '0;
	logic                  m_axis_tvalid;
	logic                  m_axis_tready = 1'b1;
	logic [OUT_DATA_W-1:0] m_axis_tdata;
	logic                  cfg_valid = 1'b0;
	logic                  cfg_ready;
	logic [CNT_W-1:0]      cfg_data = '0;

	curve_scoreboard sb = new();
	int gap_pct = 0;
	int stall_pct = 0;
	int unsigned cycle_count = 0;
	// Extremes included: empty curve, single key, full table and counts above the table size.
	int unsigned phase_counts [NPHASES] = '{1, 2, 15, 5, 0, 3, 9, 8, 4, 6, 12, 7};

	color_keyframe_curve_sampler i_dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tuser  (s_axis_tuser),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.cfg_valid     (cfg_valid),
		.cfg_ready     (cfg_ready),
		.cfg_data      (cfg_data)
	);

	always #10 clk = ~clk;

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("TEST FAILED");
			$finish;
		end
	end

	// Result side: check every accepted beat, then stall at random for the next edge.
	always @(posedge clk) begin
		if (arst_n && m_axis_tvalid && m_axis_tready)
			sb.check_color(m_axis_tdata);
		m_axis_tready <= ($urandom_range(0, 99) >= stall_pct);
	end

	function automatic curve_item_t random_fields();
		curve_item_t it;
		it.kind = 1'($urandom);
		it.key_index = KIDX_W'($urandom);
		it.key_pos = POS_W'($urandom);
		it.red = CHAN_W'($urandom);
		it.green = CHAN_W'($urandom);
		it.blue = CHAN_W'($urandom);
		it.sample_pos = SPOS_W'($urandom);
		return it;
	endfunction

	task automatic send_item(curve_item_t it);
		while ($urandom_range(0, 99) < gap_pct) begin
			s_axis_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tuser <= it.kind;
		s_axis_tdata <= IN_DATA_W'({it.sample_pos, it.blue, it.green, it.red,
			it.key_pos, it.key_index});
		do @(posedge clk); while (!s_axis_tready);
		sb.note_item(it);
	endtask

	task automatic send_write(int unsigned idx, int unsigned pos, int unsigned r,
			int unsigned g, int unsigned b);
		curve_item_t it;
		it = random_fields();
		it.kind = KIND_WRITE;
		it.key_index = KIDX_W'(idx);
		it.key_pos = POS_W'(pos);
		it.red = CHAN_W'(r);
		it.green = CHAN_W'(g);
		it.blue = CHAN_W'(b);
		send_item(it);
	endtask

	task automatic send_sample(int spos);
		curve_item_t it;
		it = random_fields();
		it.kind = KIND_SAMPLE;
		it.sample_pos = SPOS_W'(spos);
		send_item(it);
	endtask

	// The sender holds off until every color is back and the block has settled,
	// since a trailing keypoint write leaves no result to wait for.
	task automatic set_key_count(int unsigned count);
		s_axis_tvalid <= 1'b0;
		while (sb.pending() > 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
		cfg_valid <= 1'b1;
		cfg_data <= CNT_W'(count);
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
		sb.key_count = CNT_W'(count);
	endtask

	task automatic set_idling(int mode);
		case (mode)
			0: begin gap_pct = 0;  stall_pct = 0;  end
			1: begin gap_pct = 59; stall_pct = 0;  end
			2: begin gap_pct = 0;  stall_pct = 59; end
			default: begin gap_pct = 12; stall_pct = 12; end
		endcase
	endtask

	// Sorted table with random content; every third phase packs the keys
	// into a narrow window so spans of zero, one and a few LSBs show up.
	task automatic load_sorted_table(int ph);
		int unsigned pos_q [$];
		int unsigned lo, hi;
		lo = (ph % 3 == 0) ? $urandom_range(0, 65500) : 0;
		hi = (ph % 3 == 0) ? lo + 30 : 65536;
		if (hi > 65536)
			hi = 65536;
		for (int k = 0; k < MAX_KEYS_DEF; k++)
			pos_q = {pos_q, $urandom_range(lo, hi)};
		if (ph % 3 == 1) begin
			pos_q[0] = 0;
			pos_q[1] = 65536;
		end
		pos_q.sort();
		for (int k = 0; k < MAX_KEYS_DEF; k++)
			send_write(k, pos_q[k], $urandom, $urandom, $urandom);
	endtask

	task automatic random_item();
		curve_item_t it;
		int unsigned r, k, lo, hi;
		r = $urandom_range(0, 99);
		if (r < 10) begin
			// Rewrite a slot without breaking the order of its neighbors.
			k = $urandom_range(0, MAX_KEYS_DEF - 1);
			lo = (k > 0) ? sb.key_pos[k-1] : 0;
			hi = (k < MAX_KEYS_DEF - 1) ? sb.key_pos[k+1] : 65536;
			send_write(k, $urandom_range(lo, hi), $urandom, $urandom, $urandom);
		end else if (r < 12) begin
			// Noise: any slot, any 17-bit position, order not kept.
			it = random_fields();
			it.kind = KIND_WRITE;
			send_item(it);
		end else begin
			r = $urandom_range(0, 99);
			if (r < 40) begin
				send_sample($urandom_range(0, 65536));
			end else if (r < 85) begin
				k = $urandom_range(0, MAX_KEYS_DEF - 2);
				if ($urandom_range(0, 3) == 0)
					send_sample(int'(sb.key_pos[k]) + $urandom_range(0, 4) - 2);
				else
					send_sample($urandom_range(sb.key_pos[k], sb.key_pos[k+1]));
			end else begin
				it = random_fields();
				it.kind = KIND_SAMPLE;
				send_item(it);
			end
		end
	endtask

	task automatic directed_items();
		// Empty curve gives white wherever the sample lands.
		send_sample(-131072);
		send_sample(131071);
		// Full table: duplicate positions (zero span), a one-LSB span, channel
		// extremes and a position above one that is stored as one.
		send_write(0, 0, 16'hFFFF, 16'hFFFF, 16'hFFFF);
		send_write(1, 8192, 16'h0000, 16'h0000, 16'h0000);
		send_write(2, 8192, 16'h1234, 16'hFFFF, 16'h0000);
		send_write(3, 20000, 16'h1000, 16'h8000, 16'h7FFF);
		send_write(4, 40000, $urandom, $urandom, $urandom);
		send_write(5, 40001, $urandom, $urandom, $urandom);
		send_write(6, 65535, 16'h0000, 16'hFFFF, 16'hAAAA);
		send_write(7, 131071, 16'h5555, 16'h0000, 16'hFFFF);
		set_key_count(MAX_KEYS_DEF);
		// Clamping at both ends, exact keypoint hits, interior segments.
		send_sample(-131072);
		send_sample(131071);
		send_sample(0);
		send_sample(65536);
		send_sample(8192);
		send_sample(10000);
		send_sample(40000);
		send_sample(40001);
		send_sample(50000);
		send_sample(65535);
		send_sample(1);
		send_sample(30000);
		// Unsorted table: slot 4 drops below its left neighbor.
		send_write(4, 5000, $urandom, $urandom, $urandom);
		send_sample(7000);
		send_sample(30000);
	endtask

	initial begin
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		directed_items();
		for (int ph = 0; ph < NPHASES; ph++) begin
			set_idling(ph % 4);
			load_sorted_table(ph);
			set_key_count(phase_counts[ph]);
			repeat (RANDOM_PER_PHASE) random_item();
		end
		s_axis_tvalid <= 1'b0;
		while (sb.pending() > 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
		if (sb.errors == 0 && sb.pending() == 0)
			$display("TEST PASSED");
		else
			$display("TEST FAILED");
		$finish;
	end

endmodule
